// File: src/bbox_overlap_search_table_macros.svh
// Assertion macros shared by the box search table RTL
`ifndef BBOX_OVERLAP_SEARCH_TABLE_MACROS_SVH
`define BBOX_OVERLAP_SEARCH_TABLE_MACROS_SVH

// Same-cycle implication, checked out of reset
`define BOST_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bost check failed");

// Next-cycle implication, checked out of reset
`define BOST_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bost check failed");

`endif

// File: src/bost_pkg.sv
// Types, constants and codes for the box overlap search table
package bost_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int COORD_BITS  = 48;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int SLOT_W      = 6;
    localparam int BOX_W       = 4 * COORD_BITS;
    // slot and box, rounded up to whole bytes
    localparam int IN_DATA_W   = ((SLOT_W + BOX_W + 7) / 8) * 8;
    localparam int OUT_DATA_W  = 16;

    // Item kinds
    localparam logic [1:0] KIND_ADD  = 2'd0;
    localparam logic [1:0] KIND_SET  = 2'd1;
    localparam logic [1:0] KIND_ANY  = 2'd2;
    localparam logic [1:0] KIND_LIST = 2'd3;

    // Result status codes
    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_FULL       = 2'd1;
    localparam logic [1:0] ST_NOT_FILLED = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_WRITE,
        S_SCAN,
        S_DONE
    } state_t;

    // One box, left edge in the lowest bits
    typedef struct packed {
        logic signed [COORD_BITS-1:0] top_edge;
        logic signed [COORD_BITS-1:0] right_edge;
        logic signed [COORD_BITS-1:0] bottom_edge;
        logic signed [COORD_BITS-1:0] left_edge;
    } box_t;

    // One result item, hit in the lowest bit
    typedef struct packed {
        logic [1:0]        status;
        logic              last;
        logic [SLOT_W-1:0] match_slot;
        logic              hit;
    } res_t;

endpackage

// File: src/bost_ram.sv
// Generic single-port-write, single-port-read RAM with registered read
module bost_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // read port, data held when not enabled
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: src/bost_cmp.sv
// Inclusive overlap test of a query box against one stored box
module bost_cmp (
    input  bost_pkg::box_t query,
    input  bost_pkg::box_t stored,
    output logic           overlap
);

    import bost_pkg::*;

    logic x_lo_ok;
    logic x_hi_ok;
    logic y_lo_ok;
    logic y_hi_ok;

    // touching edges count as overlap
    assign x_lo_ok = query.left_edge   <= stored.right_edge;
    assign x_hi_ok = query.right_edge  >= stored.left_edge;
    assign y_lo_ok = query.bottom_edge <= stored.top_edge;
    assign y_hi_ok = query.top_edge    >= stored.bottom_edge;
    assign overlap = x_lo_ok & x_hi_ok & y_lo_ok & y_hi_ok;

endmodule

// File: src/bbox_overlap_search_table.sv
// Box table: S_WRITE registers an append or overwrite result, then S_IDLE takes the next item.
// A query scans one stored box per cycle, held while a list hit waits for the output,
// through the single RAM read port and the shared comparator; S_DONE then registers the
// final result. Every result is held on the output until taken on tready.
// Not ready while an item is in work. Reset empties the table (count to zero);
// box contents are not cleared and are never read before being written.
module bbox_overlap_search_table (
    input  logic                            clk,
    input  logic                            rst_n,
    // slave side
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // slot[5:0], left_edge[53:6], bottom_edge[101:54], right_edge[149:102],
    // top_edge[197:150], zero [199:198]
    input  logic [bost_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // kind[1:0]
    input  logic [1:0]                      s_axis_tuser,
    // master side
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // hit[0], match_slot[6:1], status[8:7], zero [15:9]
    output logic [bost_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    output logic                            m_axis_tlast
);

    import bost_pkg::*;

`include "bbox_overlap_search_table_macros.svh"

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [CNT_W-1:0]   scan_addr_reg, scan_addr_next;
    logic [IDX_W-1:0]   cmp_idx_reg, cmp_idx_next;
    logic               cmp_valid_reg, cmp_valid_next;
    logic               found_reg, found_next;
    logic               pend_valid_reg, pend_valid_next;
    logic [IDX_W-1:0]   pend_slot_reg, pend_slot_next;
    logic               out_valid_reg, out_valid_next;
    res_t               out_res_reg, out_res_next;
    logic [1:0]         kind_reg, kind_next;
    logic [SLOT_W-1:0]  slot_reg, slot_next;
    box_t               query_reg, query_next;

    logic               ram_we;
    logic [IDX_W-1:0]   ram_waddr;
    logic               ram_re;
    box_t               ram_rdata;
    logic [BOX_W-1:0]   ram_rdata_raw;
    logic               overlap;
    logic               out_free;
    logic               hit_now;
    logic               emit_pend;
    logic               is_list;

    // box store
    bost_ram #(
        .WIDTH (BOX_W),
        .DEPTH (TABLE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (query_reg),
        .re    (ram_re),
        .raddr (scan_addr_reg[IDX_W-1:0]),
        .rdata (ram_rdata_raw)
    );

    assign ram_rdata = box_t'(ram_rdata_raw);

    // shared overlap comparator
    bost_cmp u_cmp (
        .query   (query_reg),
        .stored  (ram_rdata),
        .overlap (overlap)
    );

    assign out_free  = !out_valid_reg || m_axis_tready;
    assign is_list   = (kind_reg == KIND_LIST);
    assign hit_now   = cmp_valid_reg && overlap;
    assign emit_pend = is_list && hit_now && pend_valid_reg;

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        scan_addr_next  = scan_addr_reg;
        cmp_idx_next    = cmp_idx_reg;
        cmp_valid_next  = cmp_valid_reg;
        found_next      = found_reg;
        pend_valid_next = pend_valid_reg;
        pend_slot_next  = pend_slot_reg;
        out_valid_next  = out_valid_reg && !m_axis_tready;
        out_res_next    = out_res_reg;
        kind_next       = kind_reg;
        slot_next       = slot_reg;
        query_next      = query_reg;
        ram_we          = 1'b0;
        ram_waddr       = count_reg[IDX_W-1:0];
        ram_re          = 1'b0;
        s_axis_tready   = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid)
                begin
                    kind_next       = s_axis_tuser;
                    slot_next       = s_axis_tdata[SLOT_W-1:0];
                    query_next      = box_t'(s_axis_tdata[SLOT_W +: BOX_W]);
                    scan_addr_next  = '0;
                    cmp_valid_next  = 1'b0;
                    found_next      = 1'b0;
                    pend_valid_next = 1'b0;
                    if (s_axis_tuser == KIND_ADD || s_axis_tuser == KIND_SET)
                    begin
                        state_next = S_WRITE;
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                end
            end

            S_WRITE:
            begin
                if (out_free)
                begin
                    out_valid_next          = 1'b1;
                    out_res_next.hit        = 1'b0;
                    out_res_next.match_slot = '0;
                    out_res_next.last       = 1'b1;
                    out_res_next.status     = ST_OK;
                    if (kind_reg == KIND_ADD)
                    begin
                        if (count_reg == CNT_W'(TABLE_DEPTH))
                        begin
                            out_res_next.status = ST_FULL;
                        end
                        else
                        begin
                            ram_we     = 1'b1;
                            count_next = count_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        ram_waddr = slot_reg[IDX_W-1:0];
                        if (CNT_W'(slot_reg) >= count_reg)
                        begin
                            out_res_next.status = ST_NOT_FILLED;
                        end
                        else
                        begin
                            ram_we = 1'b1;
                        end
                    end
                    state_next = S_IDLE;
                end
            end

            S_SCAN:
            begin
                // hold everything while an earlier hit waits for the output
                if (!(emit_pend && !out_free))
                begin
                    if (hit_now)
                    begin
                        found_next = 1'b1;
                        if (is_list)
                        begin
                            pend_valid_next = 1'b1;
                            pend_slot_next  = cmp_idx_reg;
                        end
                    end
                    if (emit_pend)
                    begin
                        out_valid_next          = 1'b1;
                        out_res_next.hit        = 1'b1;
                        out_res_next.match_slot = SLOT_W'(pend_slot_reg);
                        out_res_next.last       = 1'b0;
                        out_res_next.status     = ST_OK;
                    end
                    if (scan_addr_reg < count_reg)
                    begin
                        ram_re         = 1'b1;
                        cmp_idx_next   = scan_addr_reg[IDX_W-1:0];
                        scan_addr_next = scan_addr_reg + 1'b1;
                        cmp_valid_next = 1'b1;
                    end
                    else
                    begin
                        cmp_valid_next = 1'b0;
                        if (!cmp_valid_reg)
                        begin
                            state_next = S_DONE;
                        end
                    end
                end
            end

            S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next          = 1'b1;
                    out_res_next.last       = 1'b1;
                    out_res_next.status     = ST_OK;
                    out_res_next.match_slot = '0;
                    out_res_next.hit        = found_reg;
                    if (is_list && pend_valid_reg)
                    begin
                        out_res_next.match_slot = SLOT_W'(pend_slot_reg);
                    end
                    pend_valid_next = 1'b0;
                    found_next      = 1'b0;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            scan_addr_reg  <= '0;
            cmp_valid_reg  <= 1'b0;
            found_reg      <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            scan_addr_reg  <= scan_addr_next;
            cmp_valid_reg  <= cmp_valid_next;
            found_reg      <= found_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        cmp_idx_reg   <= cmp_idx_next;
        pend_slot_reg <= pend_slot_next;
        out_res_reg   <= out_res_next;
        kind_reg      <= kind_next;
        slot_reg      <= slot_next;
        query_reg     <= query_next;
    end

    // last travels on tlast, the other fields packed into tdata
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = OUT_DATA_W'({out_res_reg.status, out_res_reg.match_slot,
                                        out_res_reg.hit});
    assign m_axis_tlast  = out_res_reg.last;

    // checks
    `BOST_ASSERT_NOW(a_count_range, 1'b1, count_reg <= CNT_W'(TABLE_DEPTH))
    `BOST_ASSERT_NOW(a_idle_clean, s_axis_tready, !pend_valid_reg && !cmp_valid_reg)
    `BOST_ASSERT_NOW(a_notlast_list, m_axis_tvalid && !m_axis_tlast,
                     is_list && pend_valid_reg)
    `BOST_ASSERT_NEXT(a_count_step, state_reg != S_WRITE, count_reg == $past(count_reg))
    `BOST_ASSERT_NOW(a_read_in_range, ram_re, state_reg == S_SCAN && scan_addr_reg < count_reg)

endmodule

// File: sim/bbox_overlap_search_table_test.sv
// Self-checking testbench for the box overlap search table: directed table, then random items
module bbox_overlap_search_table_test;
    import bost_pkg::*;

    localparam int LIMIT_CYCLES = 500000;
    localparam int RANDOM_ITEMS = 220;
    localparam logic signed [COORD_BITS-1:0] MIN_COORD = {1'b1, {(COORD_BITS-1){1'b0}}};
    localparam logic signed [COORD_BITS-1:0] MAX_COORD = {1'b0, {(COORD_BITS-1){1'b1}}};

    // One row of the directed stimulus table
    typedef struct {
        logic [1:0]        kind;
        logic [SLOT_W-1:0] slot;
        box_t              box;
        bit                typed;
        res_t              want;
    } stim_row_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_valid = 1'b0;
    logic [IN_DATA_W-1:0]   s_data = '0;
    logic [1:0]             s_kind = KIND_ADD;
    logic                   m_ready = 1'b0;
    logic                   s_axis_tready;
    logic                   m_axis_tvalid;
    logic [OUT_DATA_W-1:0]  m_axis_tdata;
    logic                   m_axis_tlast;

    // Shadow copy of the box table
    box_t                   shadow_boxes [TABLE_DEPTH];
    int                     shadow_count = 0;

    res_t                   fresh_results [$];
    res_t                   awaited_results [$];
    stim_row_t              directed_rows [$];

    int                     mismatch_count = 0;
    int                     result_idx = 0;
    int                     cycle_count = 0;
    int                     rx_wait = 0;
    bit                     tx_steady = 1'b0;
    bit                     rx_steady = 1'b0;

    bbox_overlap_search_table dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_valid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_data),
        .s_axis_tuser  (s_kind),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_ready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Append one result to the list for the item being predicted
    task automatic queue_fresh(res_t r);
        fresh_results.insert(fresh_results.size(), r);
    endtask

    // Append one result to the list of results still to arrive
    task automatic queue_awaited(res_t r);
        awaited_results.insert(awaited_results.size(), r);
    endtask

    function automatic res_t single_result(logic hit, logic [1:0] status);
        res_t r;
        r.hit        = hit;
        r.match_slot = '0;
        r.last       = 1'b1;
        r.status     = status;
        return r;
    endfunction

    function automatic box_t make_box(logic signed [COORD_BITS-1:0] l,
                                      logic signed [COORD_BITS-1:0] b,
                                      logic signed [COORD_BITS-1:0] r,
                                      logic signed [COORD_BITS-1:0] t);
        box_t bx;
        bx.left_edge   = l;
        bx.bottom_edge = b;
        bx.right_edge  = r;
        bx.top_edge    = t;
        return bx;
    endfunction

    // Inclusive overlap: touching edges count
    function automatic bit boxes_touch(box_t q, box_t s);
        return ($signed(q.left_edge) <= $signed(s.right_edge)) &&
               ($signed(q.right_edge) >= $signed(s.left_edge)) &&
               ($signed(q.bottom_edge) <= $signed(s.top_edge)) &&
               ($signed(q.top_edge) >= $signed(s.bottom_edge));
    endfunction

    // Work out the results of one accepted item and update the shadow table
    task automatic predict_outcome(logic [1:0] kind, logic [SLOT_W-1:0] slot, box_t b);
        res_t r;
        bit   found;
        fresh_results = {};
        found = 1'b0;
        case (kind)
            KIND_ADD:
            begin
                if (shadow_count >= TABLE_DEPTH)
                begin
                    queue_fresh(single_result(1'b0, ST_FULL));
                end
                else
                begin
                    shadow_boxes[shadow_count] = b;
                    shadow_count++;
                    queue_fresh(single_result(1'b0, ST_OK));
                end
            end
            KIND_SET:
            begin
                if (int'(slot) >= shadow_count)
                begin
                    queue_fresh(single_result(1'b0, ST_NOT_FILLED));
                end
                else
                begin
                    shadow_boxes[slot] = b;
                    queue_fresh(single_result(1'b0, ST_OK));
                end
            end
            KIND_ANY:
            begin
                for (int i = 0; i < shadow_count; i++)
                begin
                    if (boxes_touch(b, shadow_boxes[i]))
                        found = 1'b1;
                end
                queue_fresh(single_result(found, ST_OK));
            end
            default:
            begin
                // list: one item per overlapping slot, last mark on the final one, or a single miss if none
                for (int i = 0; i < shadow_count; i++)
                begin
                    if (boxes_touch(b, shadow_boxes[i]))
                    begin
                        r.hit        = 1'b1;
                        r.match_slot = SLOT_W'(i);
                        r.last       = 1'b0;
                        r.status     = ST_OK;
                        queue_fresh(r);
                    end
                end
                if (fresh_results.size() == 0)
                    queue_fresh(single_result(1'b0, ST_OK));
                else
                    fresh_results[fresh_results.size() - 1].last = 1'b1;
            end
        endcase
    endtask

    task automatic add_row(logic [1:0] kind, logic [SLOT_W-1:0] slot, box_t b,
                           bit typed, res_t want);
        stim_row_t row;
        row.kind  = kind;
        row.slot  = slot;
        row.box   = b;
        row.typed = typed;
        row.want  = want;
        directed_rows.insert(directed_rows.size(), row);
    endtask

    // Drive one item, wait for its handshake, then queue what it should produce
    task automatic send_item(logic [1:0] kind, logic [SLOT_W-1:0] slot, box_t b,
                             bit typed, res_t want);
        int gap;
        if ($urandom_range(0, 19) == 0)
            tx_steady = !tx_steady;
        gap = tx_steady ? 0 : $urandom_range(0, 4);
        if (gap > 0)
        begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_valid <= 1'b1;
        s_kind  <= kind;
        s_data  <= IN_DATA_W'({b.top_edge, b.right_edge, b.bottom_edge, b.left_edge, slot});
        do
            @(posedge clk);
        while (!s_axis_tready);
        predict_outcome(kind, slot, b);
        if (typed)
            queue_awaited(want);
        else
            foreach (fresh_results[i])
                queue_awaited(fresh_results[i]);
    endtask

    // Mostly small coordinates so boxes collide, with extremes and full-width values
    function automatic logic signed [COORD_BITS-1:0] pick_coord();
        logic [63:0] w;
        int          v;
        case ($urandom_range(0, 15))
            0:       return MIN_COORD;
            1:       return MAX_COORD;
            2, 3:
            begin
                w = {$urandom, $urandom};
                return w[COORD_BITS-1:0];
            end
            default:
            begin
                v = $urandom_range(0, 4000);
                v = v - 2000;
                return COORD_BITS'(v);
            end
        endcase
    endfunction

    // Random box, ordered most of the time, occasionally left inverted
    function automatic box_t random_box();
        box_t                          b;
        logic signed [COORD_BITS-1:0] tmp;
        b = make_box(pick_coord(), pick_coord(), pick_coord(), pick_coord());
        if ($urandom_range(0, 9) != 0)
        begin
            if ($signed(b.left_edge) > $signed(b.right_edge))
            begin
                tmp          = b.left_edge;
                b.left_edge  = b.right_edge;
                b.right_edge = tmp;
            end
            if ($signed(b.bottom_edge) > $signed(b.top_edge))
            begin
                tmp           = b.bottom_edge;
                b.bottom_edge = b.top_edge;
                b.top_edge    = tmp;
            end
        end
        return b;
    endfunction

    task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
        $display("MISMATCH result %0d %s: got %0h want %0h", result_idx, what, got, want);
        mismatch_count++;
    endtask

    // Compare one accepted result with the oldest awaited one
    task automatic check_result();
        res_t want;
        if (awaited_results.size() == 0)
        begin
            report_mismatch("unexpected result", m_axis_tdata, '0);
            return;
        end
        want = awaited_results.pop_front();
        if (m_axis_tdata[0] !== want.hit)
            report_mismatch("hit", 16'(m_axis_tdata[0]), 16'(want.hit));
        if (m_axis_tdata[6:1] !== want.match_slot)
            report_mismatch("match_slot", 16'(m_axis_tdata[6:1]), 16'(want.match_slot));
        if (m_axis_tlast !== want.last)
            report_mismatch("last", 16'(m_axis_tlast), 16'(want.last));
        if (m_axis_tdata[8:7] !== want.status)
            report_mismatch("status", 16'(m_axis_tdata[8:7]), 16'(want.status));
    endtask

    // Result side: check, then draw a stall before the next item
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_axis_tvalid && m_ready)
            begin
                check_result();
                result_idx++;
                if ($urandom_range(0, 19) == 0)
                    rx_steady = !rx_steady;
                rx_wait = rx_steady ? 0 : $urandom_range(0, 4);
                if (rx_wait != 0)
                    m_ready <= 1'b0;
            end
            else if (!m_ready)
            begin
                if (rx_wait > 0)
                    rx_wait--;
                if (rx_wait == 0)
                    m_ready <= 1'b1;
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial
    begin
        logic [1:0]        kind;
        logic [SLOT_W-1:0] slot;
        int                pick;
        res_t              none;

        none = single_result(1'b0, ST_OK);

        // Directed table: empty table, extremes, touching, inverted, bad slots
        add_row(KIND_ANY, 6'd0, make_box(MIN_COORD, MIN_COORD, MAX_COORD, MAX_COORD),
                1'b1, single_result(1'b0, ST_OK));
        add_row(KIND_LIST, 6'd0, make_box(MIN_COORD, MIN_COORD, MAX_COORD, MAX_COORD),
                1'b1, single_result(1'b0, ST_OK));
        add_row(KIND_SET, 6'd0, make_box(0, 0, 1, 1), 1'b1, single_result(1'b0, ST_NOT_FILLED));
        add_row(KIND_ADD, 6'd0, make_box(0, 0, 100, 100), 1'b1, single_result(1'b0, ST_OK));
        add_row(KIND_ADD, 6'd63, make_box(MIN_COORD, MIN_COORD, MIN_COORD, MIN_COORD),
                1'b1, single_result(1'b0, ST_OK));
        add_row(KIND_ADD, 6'd21, make_box(MAX_COORD, MAX_COORD, MAX_COORD, MAX_COORD),
                1'b1, single_result(1'b0, ST_OK));
        add_row(KIND_ADD, 6'd42, make_box(500, 500, -500, -500), 1'b1, single_result(1'b0, ST_OK));
        add_row(KIND_ADD, 6'd0, make_box(100, 100, 200, 200), 1'b1, single_result(1'b0, ST_OK));
        add_row(KIND_LIST, 6'd0, make_box(100, 100, 100, 100), 1'b0, none);
        add_row(KIND_ANY, 6'd0, make_box(MIN_COORD, MIN_COORD, MAX_COORD, MAX_COORD), 1'b0, none);
        add_row(KIND_LIST, 6'd0, make_box(MIN_COORD, MIN_COORD, MAX_COORD, MAX_COORD), 1'b0, none);
        add_row(KIND_ANY, 6'd0, make_box(MIN_COORD, MIN_COORD, MIN_COORD, MIN_COORD), 1'b0, none);
        add_row(KIND_LIST, 6'd0, make_box(MAX_COORD, MAX_COORD, MAX_COORD, MAX_COORD), 1'b0, none);
        add_row(KIND_LIST, 6'd0, make_box(-1000, -1000, -200, -200), 1'b0, none);
        add_row(KIND_ANY, 6'd0, make_box(101, 101, 99, 99), 1'b0, none);
        add_row(KIND_SET, 6'd63, make_box(0, 0, 0, 0), 1'b1, single_result(1'b0, ST_NOT_FILLED));
        add_row(KIND_SET, 6'd5, make_box(0, 0, 0, 0), 1'b1, single_result(1'b0, ST_NOT_FILLED));
        add_row(KIND_SET, 6'd4, make_box(-50, -50, -10, -10), 1'b1, single_result(1'b0, ST_OK));
        add_row(KIND_SET, 6'd0, make_box(MIN_COORD, MIN_COORD, MAX_COORD, MAX_COORD),
                1'b1, single_result(1'b0, ST_OK));
        add_row(KIND_LIST, 6'd0, make_box(0, 0, 0, 0), 1'b0, none);
        add_row(KIND_ANY, 6'd63, make_box(-1, -1, -1, -1), 1'b0, none);
        add_row(KIND_LIST, 6'd42, make_box(-10, -10, -10, -10), 1'b0, none);

        // Reset
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            send_item(directed_rows[i].kind, directed_rows[i].slot, directed_rows[i].box,
                      directed_rows[i].typed, directed_rows[i].want);

        // Random part: appends weighted so the table fills and then overflows
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            pick = $urandom_range(0, 99);
            slot = SLOT_W'($urandom_range(0, 63));
            if (pick < 40)
                kind = KIND_ADD;
            else if (pick < 58)
            begin
                kind = KIND_SET;
                if (shadow_count > 0 && $urandom_range(0, 3) != 0)
                    slot = SLOT_W'($urandom_range(0, shadow_count - 1));
            end
            else if (pick < 78)
                kind = KIND_ANY;
            else
                kind = KIND_LIST;
            send_item(kind, slot, random_box(), 1'b0, none);
        end
        s_valid <= 1'b0;

        // Drain, then give the block time to show any stray result
        while (awaited_results.size() != 0)
            @(posedge clk);
        repeat (TABLE_DEPTH + 16) @(posedge clk);

        if (awaited_results.size() != 0)
            report_mismatch("results never arrived", 16'(awaited_results.size()), '0);
        if (mismatch_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+src
src/bost_pkg.sv
src/bost_ram.sv
src/bost_cmp.sv
src/bbox_overlap_search_table.sv
sim/bbox_overlap_search_table_test.sv
